// ----- rtl/route_table_first_match_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the route table
// Shared helpers that wrap clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ROUTE_TABLE_FIRST_MATCH_UNIT_ASSERT_SVH
`define ROUTE_TABLE_FIRST_MATCH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rtm_pkg.sv -----
// ---------------------------------------------------------------------------
// Route table package
// Types, codes and defaults shared by the route table modules.
// ---------------------------------------------------------------------------
package rtm_pkg;

  // Default number of table entries.
  localparam int DEF_TABLE_DEPTH = 16;

  // Operation codes carried with each input item.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // One stored route, already brought to the form of its family.
  typedef struct packed {
    logic        family;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [63:0] mask_high;
    logic [63:0] mask_low;
    logic [63:0] gw_high;
    logic [63:0] gw_low;
    logic        gw_given;
    logic [7:0]  flags;
    logic [31:0] metric;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One accepted request: the operation and the fitted route fields.
  typedef struct packed {
    op_t    op;
    entry_t entry;
  } item_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic [3:0]  hit_index;
    logic [63:0] gw_high;
    logic [63:0] gw_low;
    logic        gw_given;
    logic [7:0]  flags;
    logic [31:0] metric;
  } result_t;

endpackage

// ----- rtl/rtm_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ---------------------------------------------------------------------------
module rtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or registered read at one address.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/rtm_scan.sv -----
// ---------------------------------------------------------------------------
// Route table scan sequencer
// Walks the stored entries one per cycle, finds the first match and commits
// updates, inserts and clears.
// ---------------------------------------------------------------------------
`include "route_table_first_match_unit_assert.svh"

module rtm_scan #(
  parameter int TABLE_DEPTH = rtm_pkg::DEF_TABLE_DEPTH,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  rtm_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output rtm_pkg::result_t res,
  output logic             mem_en,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_addr,
  output rtm_pkg::entry_t  mem_wdata,
  input  rtm_pkg::entry_t  mem_rdata
);
  import rtm_pkg::*;

  localparam int IXW = (IDX_W > 4) ? IDX_W : 4;

  state_t           state_r, state_nxt;
  item_t            item_r, item_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  entry_t           hit_r, hit_nxt;
  logic             match;
  logic             last_cmp;
  logic             table_full;

  // Low four bits of an entry index, zero-extended for small tables.
  function automatic logic [3:0] low_index(input logic [IDX_W-1:0] idx);
    logic [IXW-1:0] wide;
    wide = IXW'(idx);
    return wide[3:0];
  endfunction

  // Lookup rule: same family and the masked destinations agree.
  function automatic logic lookup_match(input entry_t e, input entry_t q);
    return (e.family == q.family) &&
           ((q.dest_high & e.mask_high) == (e.dest_high & e.mask_high)) &&
           ((q.dest_low & e.mask_low) == (e.dest_low & e.mask_low));
  endfunction

  // Add rule: family, destination and netmask all equal.
  function automatic logic add_match(input entry_t e, input entry_t q);
    return (e.family == q.family) &&
           (e.dest_high == q.dest_high) && (e.dest_low == q.dest_low) &&
           (e.mask_high == q.mask_high) && (e.mask_low == q.mask_low);
  endfunction

  // Compare of the entry read in the previous cycle.
  always_comb begin
    if (item_r.op == OP_LOOKUP) begin
      match = cmp_vld_r && lookup_match(mem_rdata, item_r.entry);
    end else begin
      match = cmp_vld_r && add_match(mem_rdata, item_r.entry);
    end
    last_cmp   = cmp_vld_r && (CNT_W'(cmp_idx_r) == (cnt_r - CNT_W'(1)));
    table_full = (cnt_r == CNT_W'(TABLE_DEPTH));
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    issue_r     <= issue_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    hit_r       <= hit_nxt;
  end

  // Next state, memory requests and the result.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    hit_nxt       = hit_r;
    item_ready    = 1'b0;
    res_valid     = 1'b0;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = issue_r[IDX_W-1:0];
    mem_wdata     = item_r.entry;
    res           = '0;
    res.status    = ST_MISS;

    case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt  = item;
          issue_nxt = '0;
          found_nxt = 1'b0;
          if (item.op == OP_CLEAR) begin
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else if ((item.op == OP_NOP) || (cnt_r == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Evaluate the entry read last cycle, then issue the next read.
        if (match) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
          hit_nxt       = mem_rdata;
          state_nxt     = S_DONE;
        end else if (last_cmp) begin
          state_nxt = S_DONE;
        end else if (issue_r < cnt_r) begin
          mem_en      = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        case (item_r.op)
          OP_LOOKUP: begin
            if (found_r) begin
              res.status    = ST_HIT;
              res.hit_index = low_index(found_idx_r);
              res.gw_high   = hit_r.gw_high;
              res.gw_low    = hit_r.gw_low;
              res.gw_given  = hit_r.gw_given;
              res.flags     = hit_r.flags;
              res.metric    = hit_r.metric;
            end
          end
          OP_ADD: begin
            if (found_r) begin
              res.status    = ST_UPDATED;
              res.hit_index = low_index(found_idx_r);
            end else if (table_full) begin
              res.status = ST_FULL;
            end else begin
              res.status    = ST_INSERTED;
              res.hit_index = low_index(cnt_r[IDX_W-1:0]);
            end
          end
          OP_CLEAR: begin
            res.status = ST_CLEARED;
          end
          default: begin
            res.status = ST_MISS;
          end
        endcase

        // Commit the write-back as the result is handed over.
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (item_r.op == OP_ADD) begin
            if (found_r) begin
              mem_en   = 1'b1;
              mem_we   = 1'b1;
              mem_addr = found_idx_r;
            end else if (!table_full) begin
              mem_en   = 1'b1;
              mem_we   = 1'b1;
              mem_addr = cnt_r[IDX_W-1:0];
              cnt_nxt  = cnt_r + CNT_W'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Checks on the sequencer.
  `RTM_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH),
                   "entry count exceeds table depth")
  `RTM_ASSERT_SAME(a_write_on_commit, mem_we,
                   (state_r == S_DONE) && res_ready && (item_r.op == OP_ADD),
                   "table written outside an add commit")
  `RTM_ASSERT_NEXT(a_clear_empties, item_valid && item_ready && (item.op == OP_CLEAR),
                   cnt_r == '0, "clear did not empty the table")
  `RTM_ASSERT_NEXT(a_insert_grows, mem_we && !found_r,
                   cnt_r == ($past(cnt_r) + CNT_W'(1)), "insert did not grow the count")

endmodule

// ----- rtl/route_table_first_match_unit.sv -----
// ---------------------------------------------------------------------------
// Route table with masked first-match lookup
// Stream front end, family fitting and result register around the scanner.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ channel; in_tuser carries the operation and
//   the address family, in_tdata the addresses, gateway, flags and metric.
//   Each request gives exactly one result item on the out_ channel, with the
//   status in out_tuser and the matched entry's data in out_tdata.
//   Lookup and add read the stored entries one per cycle through the single
//   port of the entry memory, up to the first match or the end of the table;
//   on an empty table they read nothing and go straight to the result, as do
//   clear and the unused operation. The next request is taken as soon as the
//   result has left the scanner, so a request is never accepted while the
//   one before it is still being scanned or waits to hand on its result.
//   One request is in work at a time; in_tready is high whenever the
//   scanner is idle, even while a finished result waits in the output
//   register. If the receiver stalls, the next result is held back in the
//   scanner until the output register empties, and no new request is taken.
//   Reset empties the table at once (entry count to zero); entry contents
//   need no clearing pass, as only entries below the count are read.
// ---------------------------------------------------------------------------
module route_table_first_match_unit #(
  parameter int TABLE_DEPTH = rtm_pkg::DEF_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: op[1:0], is_ipv6[2].
  input  logic [2:0]   in_tuser,
  // Fields from bit 0 up: dest_high[63:0], dest_low[127:64],
  // mask_high[191:128], mask_low[255:192], gw_high[319:256],
  // gw_low[383:320], gw_given[384], route_flags[392:385],
  // route_metric[424:393], zero padding[431:425].
  input  logic [431:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0 up: status[2:0].
  output logic [2:0]   out_tuser,
  // Fields from bit 0 up: hit_index[3:0], out_gw_high[67:4],
  // out_gw_low[131:68], out_gw_given[132], out_flags[140:133],
  // out_metric[172:141], zero padding[175:173].
  output logic [175:0] out_tdata
);
  import rtm_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  item_t            item;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             mem_en;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;
  logic             out_tvalid_r, out_tvalid_nxt;
  result_t          out_res_r;

  // Unpack the request and bring it to the stored form of its family.
  always_comb begin
    item                 = '0;
    item.op              = op_t'(in_tuser[1:0]);
    item.entry.family    = in_tuser[2];
    item.entry.dest_high = in_tdata[63:0];
    item.entry.dest_low  = in_tdata[127:64];
    item.entry.mask_high = in_tdata[191:128];
    item.entry.mask_low  = in_tdata[255:192];
    item.entry.gw_high   = in_tdata[319:256];
    item.entry.gw_low    = in_tdata[383:320];
    item.entry.gw_given  = in_tdata[384];
    item.entry.flags     = in_tdata[392:385];
    item.entry.metric    = in_tdata[424:393];
    if (!in_tuser[2]) begin
      item.entry.dest_high = '0;
      item.entry.dest_low  = {32'd0, in_tdata[95:64]};
      item.entry.mask_high = '0;
      item.entry.mask_low  = {32'd0, in_tdata[223:192]};
      item.entry.gw_high   = '0;
      item.entry.gw_low    = {32'd0, in_tdata[351:320]};
    end
    if (!in_tdata[384]) begin
      item.entry.gw_high = '0;
      item.entry.gw_low  = '0;
    end
  end

  rtm_scan #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_tvalid),
    .item_ready(in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rtm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_ready) begin
      out_tvalid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  // Pack the result item.
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'd0, out_res_r.metric, out_res_r.flags, out_res_r.gw_given,
                       out_res_r.gw_low, out_res_r.gw_high, out_res_r.hit_index};

endmodule
